@@ sv/bcf_pkg.sv @@
`default_nettype none

package bcf_pkg;

	// item modes
	localparam logic [1:0] MODE_FILTER = 2'd0;
	localparam logic [1:0] MODE_LOAD   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	// coefficient slots within one stage
	localparam logic [2:0] SLOT_B0 = 3'd0;
	localparam logic [2:0] SLOT_B1 = 3'd1;
	localparam logic [2:0] SLOT_B2 = 3'd2;
	localparam logic [2:0] SLOT_A1 = 3'd3;
	localparam logic [2:0] SLOT_A2 = 3'd4;
	localparam int NUM_SLOTS = 5;

	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 32;
	localparam int WIDE_W   = 64;

	// multiplier operand a select
	typedef enum logic [2:0] {
		OPA_Y1_LO,
		OPA_Y1_HI,
		OPA_Y2_LO,
		OPA_Y2_HI,
		OPA_X,
		OPA_X1,
		OPA_X2,
		OPA_ZERO
	} opa_sel_t;

	// accumulator operation on the registered product
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_NEG,
		ACC_SUB,
		ACC_SUB_HI,
		ACC_SUB_HI_SHR,
		ACC_ADD
	} acc_op_t;

	// one history row per stage
	typedef struct packed {
		logic [WIDE_W-1:0]   y2;
		logic [WIDE_W-1:0]   y1;
		logic [SAMPLE_W-1:0] x2;
		logic [SAMPLE_W-1:0] x1;
	} hist_row_t;

	// sequencer to datapath controls
	typedef struct packed {
		opa_sel_t opa;
		acc_op_t  acc_op;
		logic     x_load;
		logic     commit;
		logic     out_load;
		logic     hist_valid;
	} ctl_t;

endpackage

`default_nettype wire

@@ sv/bcf_ram.sv @@
`default_nettype none

module bcf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port; read data holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/bcf_dp.sv @@
`default_nettype none

module bcf_dp #(
	parameter int FRAC_BITS = 20,
	parameter int HEADROOM_BITS = 4
) (
	input  wire logic                                  clk,
	input  wire bcf_pkg::ctl_t                         ctl,
	input  wire logic signed [bcf_pkg::SAMPLE_W-1:0]   sample,
	input  wire logic        [bcf_pkg::COEFF_W-1:0]    coeff_rdata,
	input  wire bcf_pkg::hist_row_t                    hist_rdata,
	output bcf_pkg::hist_row_t                         hist_wdata,
	output logic signed      [bcf_pkg::SAMPLE_W-1:0]   filtered
);

	localparam int PRE_SHIFT = (FRAC_BITS > HEADROOM_BITS) ? FRAC_BITS - HEADROOM_BITS : 0;
	localparam logic [bcf_pkg::WIDE_W-1:0] ROUND_ONE =
		bcf_pkg::WIDE_W'(64'd1 << (FRAC_BITS - 1));

	logic [bcf_pkg::SAMPLE_W-1:0] x_q;
	logic [bcf_pkg::WIDE_W-1:0]   prod_q;
	logic [bcf_pkg::WIDE_W-1:0]   acc_q;
	logic [bcf_pkg::SAMPLE_W-1:0] filtered_q;

	bcf_pkg::hist_row_t           row;
	logic signed [bcf_pkg::WIDE_W-1:0] y1p;
	logic signed [bcf_pkg::WIDE_W-1:0] y2p;
	logic signed [32:0]           opa;
	logic signed [64:0]           mul;
	logic [bcf_pkg::WIDE_W-1:0]   prod_hi;
	logic [bcf_pkg::WIDE_W-1:0]   sub_hi;
	logic [bcf_pkg::WIDE_W-1:0]   rsum;
	logic signed [bcf_pkg::WIDE_W-1:0] rsh;

	// history of a stage not yet run since clear reads as zero
	assign row = ctl.hist_valid ? hist_rdata : '0;

	// feedback terms are pre-shifted before the product
	assign y1p = $signed(row.y1) >>> PRE_SHIFT;
	assign y2p = $signed(row.y2) >>> PRE_SHIFT;

	// operand a: low halves unsigned, high halves and samples signed
	always_comb begin
		case (ctl.opa)
			bcf_pkg::OPA_Y1_LO: opa = {1'b0, y1p[31:0]};
			bcf_pkg::OPA_Y1_HI: opa = {y1p[63], y1p[63:32]};
			bcf_pkg::OPA_Y2_LO: opa = {1'b0, y2p[31:0]};
			bcf_pkg::OPA_Y2_HI: opa = {y2p[63], y2p[63:32]};
			bcf_pkg::OPA_X:     opa = {{17{x_q[15]}}, x_q};
			bcf_pkg::OPA_X1:    opa = {{17{row.x1[15]}}, row.x1};
			bcf_pkg::OPA_X2:    opa = {{17{row.x2[15]}}, row.x2};
			default:            opa = '0;
		endcase
	end

	// shared multiplier
	assign mul = opa * $signed({1'b0, coeff_rdata[31:0]} - {coeff_rdata[31], 32'd0});

	assign prod_hi = {prod_q[31:0], 32'd0};
	assign sub_hi  = acc_q - prod_hi;

	// rounding of the wide stage output to the next sample
	assign rsum = acc_q + ROUND_ONE;
	assign rsh  = $signed(rsum) >>> FRAC_BITS;

	// product register
	always_ff @(posedge clk) begin
		prod_q <= mul[63:0];
	end

	// accumulator
	always_ff @(posedge clk) begin
		case (ctl.acc_op)
			bcf_pkg::ACC_NEG:        acc_q <= '0 - prod_q;
			bcf_pkg::ACC_SUB:        acc_q <= acc_q - prod_q;
			bcf_pkg::ACC_SUB_HI:     acc_q <= sub_hi;
			bcf_pkg::ACC_SUB_HI_SHR: acc_q <= $signed(sub_hi) >>> HEADROOM_BITS;
			bcf_pkg::ACC_ADD:        acc_q <= acc_q + prod_q;
			default:                 acc_q <= acc_q;
		endcase
	end

	// stage input sample and output register
	always_ff @(posedge clk) begin
		if (ctl.x_load) begin
			x_q <= sample;
		end else if (ctl.commit) begin
			x_q <= rsh[15:0];
		end
		if (ctl.out_load) begin
			filtered_q <= x_q;
		end
	end

	// history row written back at the end of a stage
	always_comb begin
		hist_wdata.y2 = row.y1;
		hist_wdata.y1 = acc_q;
		hist_wdata.x2 = row.x1;
		hist_wdata.x1 = x_q;
	end

	assign filtered = filtered_q;

endmodule

`default_nettype wire

@@ sv/bcf_ctrl.sv @@
`default_nettype none

module bcf_ctrl #(
	parameter int MAX_STAGES = 8,
	localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1,
	localparam int CW = $clog2(MAX_STAGES + 1),
	localparam int CAW = $clog2(MAX_STAGES * bcf_pkg::NUM_SLOTS)
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [1:0]     mode,
	input  wire logic [2:0]     stage_index,
	input  wire logic [2:0]     coeff_index,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire logic           cfg_wr_en,
	input  wire logic [3:0]     cfg_wr_data,
	output bcf_pkg::ctl_t       ctl,
	output logic                coeff_we,
	output logic [CAW-1:0]      coeff_waddr,
	output logic                coeff_re,
	output logic [CAW-1:0]      coeff_raddr,
	output logic                hist_we,
	output logic [IW-1:0]       hist_waddr,
	output logic                hist_re,
	output logic [IW-1:0]       hist_raddr
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [3:0] S0 = 4'd0;
	localparam logic [3:0] S1 = 4'd1;
	localparam logic [3:0] S2 = 4'd2;
	localparam logic [3:0] S3 = 4'd3;
	localparam logic [3:0] S4 = 4'd4;
	localparam logic [3:0] S5 = 4'd5;
	localparam logic [3:0] S6 = 4'd6;
	localparam logic [3:0] S7 = 4'd7;
	localparam logic [3:0] S8 = 4'd8;
	localparam logic [3:0] S9 = 4'd9;

	logic [1:0]            state_q;
	logic [3:0]            step_q;
	logic [IW-1:0]         stage_q;
	logic [CW-1:0]         n_q;
	logic [CAW-1:0]        base_q;
	logic [MAX_STAGES-1:0] hv_q;
	logic [3:0]            stage_count_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  out_take;
	logic                  out_free;
	logic [CW-1:0]         n_eff;
	logic [CW-1:0]         stage_next;
	logic                  last_stage;
	logic [CAW-1:0]        rd_base;
	logic [2:0]            rd_slot;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_take  = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// active stages, limited to what is built
	always_comb begin
		if (32'(stage_count_q) > MAX_STAGES) begin
			n_eff = CW'(MAX_STAGES);
		end else begin
			n_eff = CW'(stage_count_q);
		end
	end

	assign stage_next = CW'(stage_q) + CW'(1);
	assign last_stage = (stage_next == n_q);

	// step nine also issues the reads of the following stage
	assign rd_base    = (step_q == S9) ? CAW'(32'(base_q) + bcf_pkg::NUM_SLOTS) : base_q;
	assign hist_raddr = (step_q == S9) ? IW'(32'(stage_q) + 1) : stage_q;
	assign hist_re    = (state_q == ST_RUN) && ((step_q == S0) || (step_q == S9));
	assign hist_we    = ctl.commit;
	assign hist_waddr = stage_q;

	// coefficient read schedule
	always_comb begin
		coeff_re = 1'b0;
		rd_slot  = bcf_pkg::SLOT_A1;
		if (state_q == ST_RUN) begin
			case (step_q)
				S0, S9: begin
					coeff_re = 1'b1;
					rd_slot  = bcf_pkg::SLOT_A1;
				end
				S2: begin
					coeff_re = 1'b1;
					rd_slot  = bcf_pkg::SLOT_A2;
				end
				S4: begin
					coeff_re = 1'b1;
					rd_slot  = bcf_pkg::SLOT_B0;
				end
				S5: begin
					coeff_re = 1'b1;
					rd_slot  = bcf_pkg::SLOT_B1;
				end
				S6: begin
					coeff_re = 1'b1;
					rd_slot  = bcf_pkg::SLOT_B2;
				end
				default: begin
					coeff_re = 1'b0;
				end
			endcase
		end
	end
	assign coeff_raddr = CAW'(32'(rd_base) + 32'(rd_slot));

	// coefficient writes from load items
	assign coeff_we = accept && (mode == bcf_pkg::MODE_LOAD)
		&& (32'(stage_index) < MAX_STAGES) && (32'(coeff_index) < bcf_pkg::NUM_SLOTS);
	assign coeff_waddr = CAW'(32'(stage_index) * bcf_pkg::NUM_SLOTS + 32'(coeff_index));

	// multiplier and accumulator schedule
	always_comb begin
		ctl.opa        = bcf_pkg::OPA_ZERO;
		ctl.acc_op     = bcf_pkg::ACC_HOLD;
		ctl.x_load     = accept && (mode == bcf_pkg::MODE_FILTER);
		ctl.commit     = (state_q == ST_RUN) && (step_q == S9);
		ctl.out_load   = (state_q == ST_DONE) && out_free;
		ctl.hist_valid = hv_q[stage_q];
		if (state_q == ST_RUN) begin
			case (step_q)
				S1: ctl.opa = bcf_pkg::OPA_Y1_LO;
				S2: begin
					ctl.opa    = bcf_pkg::OPA_Y1_HI;
					ctl.acc_op = bcf_pkg::ACC_NEG;
				end
				S3: begin
					ctl.opa    = bcf_pkg::OPA_Y2_LO;
					ctl.acc_op = bcf_pkg::ACC_SUB_HI;
				end
				S4: begin
					ctl.opa    = bcf_pkg::OPA_Y2_HI;
					ctl.acc_op = bcf_pkg::ACC_SUB;
				end
				S5: begin
					ctl.opa    = bcf_pkg::OPA_X;
					ctl.acc_op = bcf_pkg::ACC_SUB_HI_SHR;
				end
				S6: begin
					ctl.opa    = bcf_pkg::OPA_X1;
					ctl.acc_op = bcf_pkg::ACC_ADD;
				end
				S7: begin
					ctl.opa    = bcf_pkg::OPA_X2;
					ctl.acc_op = bcf_pkg::ACC_ADD;
				end
				S8: ctl.acc_op = bcf_pkg::ACC_ADD;
				default: ctl.opa = bcf_pkg::OPA_ZERO;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= S0;
			stage_q <= '0;
			n_q     <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == bcf_pkg::MODE_FILTER)) begin
						n_q     <= n_eff;
						stage_q <= '0;
						base_q  <= '0;
						step_q  <= S0;
						state_q <= (n_eff == '0) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_q == S9) begin
						if (last_stage) begin
							state_q <= ST_DONE;
						end else begin
							stage_q <= IW'(stage_next);
							base_q  <= rd_base;
							step_q  <= S1;
						end
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// history valid bits, per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= '0;
		end else if (accept && (mode == bcf_pkg::MODE_CLEAR)) begin
			hv_q <= '0;
		end else if (ctl.commit) begin
			hv_q[stage_q] <= 1'b1;
		end
	end

	// stage count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_count_q <= '0;
		end else if (cfg_wr_en) begin
			stage_count_q <= cfg_wr_data;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	// a result only appears after the cascade has finished
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without a finished cascade");

	// the running stage is always one of the active ones
	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (CW'(stage_q) < n_q))
		else $error("running stage beyond active count");

	// the step counter never passes the commit step
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q <= S9))
		else $error("step counter out of range");

	// a clear item leaves no stage history valid
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == bcf_pkg::MODE_CLEAR)) |=> (hv_q == '0))
		else $error("history not cleared");

endmodule

`default_nettype wire

@@ sv/biquad_cascade_filter_core.sv @@
// Cascade of Direct Form I biquads on 16-bit samples, Q(FRAC_BITS) coefficients.
// Input channel (in_valid / in_stall) carries mode, sample, stage_index,
// coeff_index and coeff_value; an item is taken when in_valid is high and
// in_stall is low. Mode 0 filters a sample, mode 1 writes one coefficient,
// mode 2 clears the history of all stages, mode 3 does nothing.
// Output channel (out_valid / out_stall) carries filtered, one per mode 0 item.
// stage_count is written through cfg_wr_en / cfg_wr_data, by the user only
// while idle; the block itself does not enforce this. One shared 33x32
// multiplier does seven partial products per stage, one per cycle, plus a
// commit step. With no active stage the sample itself is the result. A new
// item is taken only once the previous mode 0 result is in the output register;
// load, clear and mode 3 items are taken back to back.
// Reset clears stage_count and all stage history; coefficients are undefined
// until loaded. While out_stall is high a finished result waits in the
// output register; the next item is still taken and computed, and the input
// stalls once that next result is ready while the register is still full.
`default_nettype none

module biquad_cascade_filter_core #(
	parameter int MAX_STAGES = 8,
	parameter int FRAC_BITS = 20,
	parameter int HEADROOM_BITS = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [1:0]  mode,
	input  wire logic signed [15:0] sample,
	input  wire logic        [2:0]  stage_index,
	input  wire logic        [2:0]  coeff_index,
	input  wire logic signed [31:0] coeff_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [15:0] filtered,
	input  wire logic               cfg_wr_en,
	input  wire logic        [3:0]  cfg_wr_data
);

	localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CDEPTH = MAX_STAGES * bcf_pkg::NUM_SLOTS;
	localparam int CAW = $clog2(CDEPTH);

	bcf_pkg::ctl_t      ctl;
	bcf_pkg::hist_row_t hist_rdata;
	bcf_pkg::hist_row_t hist_wdata;
	logic                         coeff_we;
	logic [CAW-1:0]               coeff_waddr;
	logic                         coeff_re;
	logic [CAW-1:0]               coeff_raddr;
	logic [bcf_pkg::COEFF_W-1:0]  coeff_rdata;
	logic                         hist_we;
	logic [IW-1:0]                hist_waddr;
	logic                         hist_re;
	logic [IW-1:0]                hist_raddr;

	// sequencer, handshakes and configuration
	bcf_ctrl #(
		.MAX_STAGES(MAX_STAGES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.stage_index (stage_index),
		.coeff_index (coeff_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ctl         (ctl),
		.coeff_we    (coeff_we),
		.coeff_waddr (coeff_waddr),
		.coeff_re    (coeff_re),
		.coeff_raddr (coeff_raddr),
		.hist_we     (hist_we),
		.hist_waddr  (hist_waddr),
		.hist_re     (hist_re),
		.hist_raddr  (hist_raddr)
	);

	// coefficient store, five per stage
	bcf_ram #(
		.WIDTH (bcf_pkg::COEFF_W),
		.DEPTH (CDEPTH),
		.ADDR_W(CAW)
	) u_coeff_ram (
		.clk  (clk),
		.we   (coeff_we),
		.waddr(coeff_waddr),
		.wdata(coeff_value),
		.re   (coeff_re),
		.raddr(coeff_raddr),
		.rdata(coeff_rdata)
	);

	// stage history, one row per stage
	bcf_ram #(
		.WIDTH ($bits(bcf_pkg::hist_row_t)),
		.DEPTH (MAX_STAGES),
		.ADDR_W(IW)
	) u_hist_ram (
		.clk  (clk),
		.we   (hist_we),
		.waddr(hist_waddr),
		.wdata(hist_wdata),
		.re   (hist_re),
		.raddr(hist_raddr),
		.rdata(hist_rdata)
	);

	// shared multiply-accumulate datapath
	bcf_dp #(
		.FRAC_BITS    (FRAC_BITS),
		.HEADROOM_BITS(HEADROOM_BITS)
	) u_dp (
		.clk        (clk),
		.ctl        (ctl),
		.sample     (sample),
		.coeff_rdata(coeff_rdata),
		.hist_rdata (hist_rdata),
		.hist_wdata (hist_wdata),
		.filtered   (filtered)
	);

endmodule

`default_nettype wire
